@@ hw/rtl/phs_pkg.sv @@
// Shared types and constants of the pixel histogram with peak scaling.
// Depends on nothing; every other file of the block imports it.
package phs_pkg;

  localparam int NUM_BINS_DEF    = 256;
  localparam int COUNT_WIDTH_DEF = 21;

  localparam int SAMPLE_W  = 8;
  localparam int HEIGHT_W  = 10;
  localparam int CHAN_W    = 2;
  localparam int OUT_CNT_W = 21;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 10;

  localparam logic [HEIGHT_W-1:0] CANVAS_HEIGHT_RST = 10'd125;

  typedef enum logic [1:0] {
    REQ_PIXEL = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_type_t;

  typedef enum logic [CHAN_W-1:0] {
    CH_BLUE  = 2'd0,
    CH_GREEN = 2'd1,
    CH_RED   = 2'd2
  } chan_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_SELECT = 1'd0,
    CFG_CANVAS_HEIGHT  = 1'd1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    req_type_t           req_type;
    logic [SAMPLE_W-1:0] blue;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] bin_index;
  } in_req_t;

  typedef struct packed {
    logic [OUT_CNT_W-1:0] bin_count;
    logic [OUT_CNT_W-1:0] peak_count;
    logic [HEIGHT_W-1:0]  bar_top_row;
  } out_res_t;

endpackage

@@ hw/rtl/phs_in_if.sv @@
// Request channel of the pixel histogram: valid/ready plus the request payload.
// Depends on phs_pkg.
interface phs_in_if;
  import phs_pkg::*;

  logic    valid;
  logic    ready;
  in_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/phs_out_if.sv @@
// Result channel of the pixel histogram: valid/ready plus the result payload.
// Depends on phs_pkg.
interface phs_out_if;
  import phs_pkg::*;

  logic     valid;
  logic     ready;
  out_res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/pixel_histogram_with_peak_scaling_top.sv @@
// Pixel histogram with peak tracking and bar scaling, top level.
// Depends on phs_pkg, phs_in_if and phs_out_if.
//
// Usage:
//   in_req  : request channel (valid/ready). A request is taken when valid and
//             ready are both high. Kinds: pixel (count the selected channel
//             sample), read (return one bin), clear (zero all bins and peak).
//   out_res : result channel, one result per read request, held in an output
//             register until the receiver takes it.
//   cfg_*   : write port; cfg_idx picks channel_select or canvas_height.
// Throughput: pixel and clear requests go at one per cycle while no read is in
//   flight. The bin memory is read at acceptance and written back in the cycle
//   after; a pixel that hits the bin written in the cycle before takes the
//   forwarded value. A read request passes stage 1, the multiply and prepare
//   states, then goes to the output register when peak <= canvas_height; when
//   scaling applies the restoring divider first makes one quotient bit per cycle
//   over COUNT_WIDTH + 11 bits. No request is taken while a read is in flight.
// Stall: while a result waits, pixel and clear requests keep being taken;
//   a following read finishes its arithmetic and then waits for the slot.
// Reset: clears the per-bin valid flags, the peak and the registers
//   (channel blue, height 125); no clearing pass over memory.
module pixel_histogram_with_peak_scaling_top #(
  parameter int NUM_BINS    = phs_pkg::NUM_BINS_DEF,
  parameter int COUNT_WIDTH = phs_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  phs_in_if.sink                         in_req,
  phs_out_if.source                      out_res,
  input  logic                           cfg_we,
  input  logic [phs_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [phs_pkg::CFG_DAT_W-1:0]  cfg_wdata
);
  import phs_pkg::*;

  localparam int IDX_W  = $clog2(NUM_BINS);
  localparam int PROD_W = COUNT_WIDTH + HEIGHT_W;
  localparam int DIV_N  = PROD_W + 1;
  localparam int DCNT_W = $clog2(DIV_N + 1);
  localparam logic [SAMPLE_W:0]      BIN_LIMIT = (SAMPLE_W + 1)'(NUM_BINS);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // ---------------- configuration registers
  chan_t               chan_sel_r;
  logic [HEIGHT_W-1:0] height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_sel_r <= CH_BLUE;
      height_r   <= CANVAS_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_CHANNEL_SELECT: chan_sel_r <= chan_t'(cfg_wdata[CHAN_W-1:0]);
        CFG_CANVAS_HEIGHT:  height_r   <= cfg_wdata[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- stage 0: accept request, issue memory read
  state_t state_r, state_nxt;
  logic   s1_valid_r;
  req_type_t s1_type_r;
  logic [IDX_W-1:0] s1_addr_r;
  logic   s1_inr_r;

  logic                in_fire;
  logic [SAMPLE_W-1:0] sample;
  logic [SAMPLE_W-1:0] sel_idx;
  logic [IDX_W-1:0]    rd_addr;
  logic                sel_inr;

  // a read in stage 1 or in the scaling unit blocks new requests
  assign in_req.ready = (state_r == ST_IDLE) && !(s1_valid_r && s1_type_r == REQ_READ);
  assign in_fire      = in_req.valid && in_req.ready;

  always_comb begin
    case (chan_sel_r)
      CH_GREEN: sample = in_req.data.green;
      CH_RED:   sample = in_req.data.red;
      default:  sample = in_req.data.blue;   // blue, and the unused code
    endcase
  end

  assign sel_idx = (in_req.data.req_type == REQ_READ) ? in_req.data.bin_index : sample;
  assign sel_inr = {1'b0, sel_idx} < BIN_LIMIT;
  assign rd_addr = sel_idx[IDX_W-1:0];

  // ---------------- bin memory, synchronous read
  logic [COUNT_WIDTH-1:0] mem [NUM_BINS];
  logic [COUNT_WIDTH-1:0] mem_rd_r;
  logic [NUM_BINS-1:0]    valid_r;    // bin holds a written count since clear

  always_ff @(posedge clk) begin
    if (in_fire && sel_inr) begin
      mem_rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_type_r <= in_req.data.req_type;
      s1_addr_r <= rd_addr;
      s1_inr_r  <= sel_inr;
    end
  end

  // ---------------- stage 1: modify and write back
  logic                   wr_last_r;
  logic [IDX_W-1:0]       wr_addr_r;
  logic [COUNT_WIDTH-1:0] wr_data_r;
  logic [COUNT_WIDTH-1:0] peak_r;

  logic                   fwd;
  logic [COUNT_WIDTH-1:0] stored;
  logic [COUNT_WIDTH-1:0] cur;
  logic [COUNT_WIDTH-1:0] inc;
  logic                   px_wr;
  logic                   clr;
  logic                   rd_go;

  // the write of the cycle before is not yet seen by this item's read
  assign fwd    = wr_last_r && (wr_addr_r == s1_addr_r);
  assign stored = fwd ? wr_data_r : (valid_r[s1_addr_r] ? mem_rd_r : '0);
  assign cur    = s1_inr_r ? stored : '0;
  assign inc    = (cur == COUNT_MAX) ? cur : cur + 1'b1;

  assign px_wr = s1_valid_r && (s1_type_r == REQ_PIXEL) && s1_inr_r;
  assign clr   = s1_valid_r && (s1_type_r == REQ_CLEAR);
  assign rd_go = s1_valid_r && (s1_type_r == REQ_READ);

  always_ff @(posedge clk) begin
    if (px_wr) begin
      mem[s1_addr_r] <= inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      valid_r <= '0;
      peak_r  <= '0;
    end else if (px_wr) begin
      valid_r[s1_addr_r] <= 1'b1;
      if (inc > peak_r) begin
        peak_r <= inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_last_r <= 1'b0;
    end else begin
      wr_last_r <= px_wr;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r <= s1_addr_r;
    wr_data_r <= inc;
  end

  // ---------------- read scaling: multiply, then restoring divide
  logic [COUNT_WIDTH-1:0] cnt_r;
  logic [COUNT_WIDTH-1:0] pk_r;
  logic [PROD_W-1:0]      prod_r;
  logic [DIV_N-1:0]       num_r;
  logic [COUNT_WIDTH:0]   rem_r;
  logic [DCNT_W-1:0]      dcnt_r;
  logic [HEIGHT_W-1:0]    scaled_r;

  logic                   do_scale;
  logic [PROD_W-1:0]      cnt_ext;
  logic [PROD_W-1:0]      hgt_prod;
  logic [DIV_N-1:0]       hgt_div;
  logic [COUNT_WIDTH:0]   shifted;
  logic                   ge;
  logic                   out_load;

  assign do_scale = PROD_W'(pk_r) > hgt_prod;
  assign cnt_ext  = PROD_W'(cnt_r);
  assign hgt_prod = PROD_W'(height_r);
  assign hgt_div  = DIV_N'(height_r);
  assign shifted  = {rem_r[COUNT_WIDTH-1:0], num_r[DIV_N-1]};
  assign ge       = shifted >= {1'b0, pk_r};

  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: if (rd_go) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_PREP;
      ST_PREP: state_nxt = do_scale ? ST_DIV : ST_DONE;
      ST_DIV:  if (dcnt_r == '0) state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_res.valid || out_res.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (rd_go) begin
          cnt_r <= cur;
          pk_r  <= peak_r;
        end
      end
      ST_MUL: prod_r <= cnt_ext * hgt_prod;
      ST_PREP: begin
        num_r  <= DIV_N'(prod_r) + DIV_N'(pk_r) - DIV_N'(1);
        rem_r  <= '0;
        dcnt_r <= DCNT_W'(DIV_N);
        // unscaled bar: count is never above the peak, clamp kept for safety
        scaled_r <= (cnt_ext > hgt_prod) ? height_r : cnt_ext[HEIGHT_W-1:0];
      end
      ST_DIV: begin
        if (dcnt_r != '0) begin
          rem_r  <= ge ? shifted - {1'b0, pk_r} : shifted;
          num_r  <= {num_r[DIV_N-2:0], ge};
          dcnt_r <= dcnt_r - 1'b1;
        end else begin
          scaled_r <= (num_r > hgt_div) ? height_r : num_r[HEIGHT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // ---------------- output register
  logic     out_valid_r;
  out_res_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.bin_count   <= OUT_CNT_W'(cnt_r);
      out_data_r.peak_count  <= OUT_CNT_W'(pk_r);
      out_data_r.bar_top_row <= height_r - scaled_r;
    end
  end

  assign out_res.valid = out_valid_r;
  assign out_res.data  = out_data_r;

endmodule
